// ===== src/lrfs_pkg.sv =====
// shared constants, types and request struct for the line raster frame store
package lrfs_pkg;

	localparam int SCREEN_WIDTH    = 240;
	localparam int SCREEN_HEIGHT   = 128;
	localparam int ROW_BYTES       = SCREEN_WIDTH / 8;
	localparam int STORE_BYTES     = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int IDX_W           = 13;
	localparam int MAX_LINE_PIXELS = 256;
	localparam int CNT_W           = 9;
	localparam int ERR_W           = 11;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_SET   = 2'd1,
		OP_LINE  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic              set;
		logic              zero;
		logic              look;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
	} rmw_req_t;

endpackage

// ===== src/line_raster_frame_store.sv =====
// top level: op sequencer, line walker and result register of the frame store
//
//  channel | beat fields                                        | handshake
//  in      | op start_x start_y end_x end_y byte_address        | in_valid / in_stall
//  out     | read_data pixel_count any_clipped                  | out_valid / out_stall
//
// one item at a time; set and line pass through the line, drain and done states, read through read and done
// a line plots one pixel per cycle through the store read-modify-write port
// clear sweeps the store one byte per cycle over all STORE_BYTES (3840) bytes
// after reset the same zero sweep runs before the first beat is taken
// the next beat is taken while a result waits behind a stalled out channel
module line_raster_frame_store import lrfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [11:0] byte_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [8:0]  pixel_count,
	output logic        any_clipped
);

	typedef enum logic [5:0] {
		ST_SWEEP = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LINE  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_READ  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic              report_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [7:0]        x_q, y_q, ex_q, ey_q, dx_q, ady_q;
	logic              sxn_q, syn_q;
	logic signed [ERR_W-1:0] err_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              clip_q;
	logic [7:0]        data_q;
	logic              range_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_clip_q;

	rmw_req_t          req;
	logic [7:0]        rd_data;
	logic              accept;
	op_t               op_in;
	logic [7:0]        ex_in, ey_in;
	logic [IDX_W-1:0]  bx;
	logic              rd_in_range;
	logic [IDX_W-1:0]  idx;
	logic              on_screen;
	logic signed [ERR_W:0] e2, dx_w, dy_w, err_a, err_b;
	logic              stepx, stepy, hit_x, hit_y;
	logic              brk0, brk1, brk2, done, go_x, go_y;
	logic [CNT_W-1:0]  cnt_nx;
	logic              out_free;

	assign accept      = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign op_in       = op_t'(op);
	assign ex_in       = (op_in == OP_SET) ? start_x : end_x;
	assign ey_in       = (op_in == OP_SET) ? start_y : end_y;
	assign bx          = IDX_W'(byte_address);
	assign rd_in_range = bx < IDX_W'(STORE_BYTES);

	assign idx       = IDX_W'(x_q[7:3]) + IDX_W'(y_q) * IDX_W'(ROW_BYTES);
	assign on_screen = ({1'b0, x_q} < 9'(SCREEN_WIDTH)) && ({1'b0, y_q} < 9'(SCREEN_HEIGHT))
		&& (idx < IDX_W'(STORE_BYTES));

	assign e2     = {err_q, 1'b0};
	assign dx_w   = signed'({4'd0, dx_q});
	assign dy_w   = -signed'({4'd0, ady_q});
	assign stepx  = e2 >= dy_w;
	assign stepy  = e2 <= dx_w;
	assign hit_x  = x_q == ex_q;
	assign hit_y  = y_q == ey_q;
	assign cnt_nx = cnt_q + CNT_W'(1);
	assign brk0   = (hit_x && hit_y) || (cnt_nx == CNT_W'(MAX_LINE_PIXELS));
	assign brk1   = !brk0 && stepx && hit_x;
	assign brk2   = !brk0 && !brk1 && stepy && hit_y;
	assign done   = brk0 || brk1 || brk2;
	assign go_x   = !brk0 && stepx && !hit_x;
	assign go_y   = !brk0 && !brk1 && stepy && !hit_y;
	assign err_a  = {err_q[ERR_W-1], err_q} + (go_x ? dy_w : '0);
	assign err_b  = err_a + (go_y ? dx_w : '0);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		req      = '0;
		req.mask = 8'd1 << x_q[2:0];
		unique case (state_q)
			ST_IDLE: begin
				req.look = accept && (op_in == OP_READ);
				req.addr = rd_in_range ? bx[ADDR_W-1:0] : '0;
			end
			ST_SWEEP: begin
				req.zero = 1'b1;
				req.addr = sweep_q;
			end
			ST_LINE: begin
				req.set  = on_screen;
				req.addr = idx[ADDR_W-1:0];
			end
			ST_DRAIN, ST_READ, ST_DONE: begin
				req.addr = '0;
			end
			default: begin
				req.addr = '0;
			end
		endcase
	end

	lrfs_rmw u_rmw (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			report_q    <= 1'b0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= report_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (op_in)
							OP_CLEAR: begin
								state_q  <= ST_SWEEP;
								report_q <= 1'b1;
								sweep_q  <= '0;
							end
							OP_SET, OP_LINE: state_q <= ST_LINE;
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LINE: begin
					if (done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q   <= '0;
			clip_q  <= 1'b0;
			data_q  <= 8'd0;
			range_q <= rd_in_range;
			x_q     <= start_x;
			y_q     <= start_y;
			ex_q    <= ex_in;
			ey_q    <= ey_in;
			sxn_q   <= !(start_x < ex_in);
			syn_q   <= !(start_y < ey_in);
			dx_q    <= (start_x < ex_in) ? (ex_in - start_x) : (start_x - ex_in);
			ady_q   <= (start_y < ey_in) ? (ey_in - start_y) : (start_y - ey_in);
			err_q   <= ERR_W'(signed'({3'd0, ((start_x < ex_in) ? (ex_in - start_x)
				: (start_x - ex_in))}) - signed'({3'd0, ((start_y < ey_in)
				? (ey_in - start_y) : (start_y - ey_in))}));
		end
		if (state_q == ST_LINE) begin
			cnt_q  <= cnt_nx;
			clip_q <= clip_q || !on_screen;
			err_q  <= err_b[ERR_W-1:0];
			if (go_x) begin
				x_q <= sxn_q ? (x_q - 8'd1) : (x_q + 8'd1);
			end
			if (go_y) begin
				y_q <= syn_q ? (y_q - 8'd1) : (y_q + 8'd1);
			end
		end
		if (state_q == ST_READ) begin
			data_q <= range_q ? rd_data : 8'd0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= data_q;
			out_cnt_q  <= cnt_q;
			out_clip_q <= clip_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign pixel_count = out_cnt_q;
	assign any_clipped = out_clip_q;

	a_drain_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_LINE)
		else $error("drain entered without a line walk");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINE |-> cnt_q < CNT_W'(MAX_LINE_PIXELS))
		else $error("line walk ran past the pixel limit");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && out_stall |=> state_q == ST_DONE)
		else $error("result left while the output slot was full");
	a_read_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(accept) && $past(op_in == OP_READ))
		else $error("byte read state without a read beat");

endmodule

// ===== src/lrfs_rmw.sv =====
// frame store memory with read-modify-write pipeline and write forwarding
module lrfs_rmw import lrfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rmw_req_t req,
	output logic [7:0] rd_data
);

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        mem_q;
	logic              set_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic              wr_v_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [7:0]        wr_data_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [7:0]        merged;

	assign merged  = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : mem_q;
	assign rd_data = merged;
	assign we      = set_s1 || req.zero;
	assign waddr   = set_s1 ? addr_s1 : req.addr;
	assign wdata   = set_s1 ? (merged | mask_s1) : 8'd0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_s1 <= 1'b0;
			wr_v_q <= 1'b0;
		end else begin
			set_s1 <= req.set;
			wr_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= req.addr;
		mask_s1   <= req.mask;
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
	end

	a_zero_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req.zero |-> !set_s1)
		else $error("clear write collides with pending pixel write");
	a_set_not_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req.set |-> !req.zero && !req.look)
		else $error("pixel request mixed with another request");
	a_look_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req.look |-> !set_s1)
		else $error("byte read issued while a pixel write is pending");

endmodule
